// ===== src/dabp_pkg.sv =====
package dabp_pkg;

   // blink shapes: plain blink, double flash, triple flash, far band slow blink
   typedef enum logic [1:0] {
      PAT_CAM,
      PAT_DBL,
      PAT_TRI,
      PAT_FAR
   } pat_type;

   // cycle lengths in ms that a pattern can need
   typedef enum logic [3:0] {
      M1200,
      M800,
      M560,
      M360,
      M180,
      M1600,
      M1120,
      M720,
      M840,
      M540
   } modsel_type;

   typedef enum logic [7:0] {
      CSR_ALERT_ENABLED   = 8'd0,
      CSR_PIN_ACTIVE_HIGH = 8'd1,
      CSR_INTERSECT_KIND  = 8'd2,
      CSR_CLUSTER_KIND    = 8'd3
   } csr_type;

   localparam int NUM_MOD = 10;
   localparam int MOD_W   = 11;
   localparam int HALF_W  = 10;
   localparam int PROD_W  = 19;
   localparam int SUM_W   = 21;
   localparam int RECIP_W = 25;
   localparam int QUO_W   = 13;
   localparam int REM_W   = 11;
   localparam int CMP_W   = 12;
   localparam int FRAC_SH = 32;

   localparam int unsigned MOD_VAL [NUM_MOD] =
      '{1200, 800, 560, 360, 180, 1600, 1120, 720, 840, 540};

   // weights of bytes 1..3 of the time word, reduced by each cycle length
   localparam int unsigned W1_VAL [NUM_MOD] = '{
      256 % MOD_VAL[0], 256 % MOD_VAL[1], 256 % MOD_VAL[2], 256 % MOD_VAL[3],
      256 % MOD_VAL[4], 256 % MOD_VAL[5], 256 % MOD_VAL[6], 256 % MOD_VAL[7],
      256 % MOD_VAL[8], 256 % MOD_VAL[9]};
   localparam int unsigned W2_VAL [NUM_MOD] = '{
      65536 % MOD_VAL[0], 65536 % MOD_VAL[1], 65536 % MOD_VAL[2],
      65536 % MOD_VAL[3], 65536 % MOD_VAL[4], 65536 % MOD_VAL[5],
      65536 % MOD_VAL[6], 65536 % MOD_VAL[7], 65536 % MOD_VAL[8],
      65536 % MOD_VAL[9]};
   localparam int unsigned W3_VAL [NUM_MOD] = '{
      16777216 % MOD_VAL[0], 16777216 % MOD_VAL[1], 16777216 % MOD_VAL[2],
      16777216 % MOD_VAL[3], 16777216 % MOD_VAL[4], 16777216 % MOD_VAL[5],
      16777216 % MOD_VAL[6], 16777216 % MOD_VAL[7], 16777216 % MOD_VAL[8],
      16777216 % MOD_VAL[9]};
   // floor(2^32 / m)
   localparam longint unsigned RECIP_VAL [NUM_MOD] = '{
      64'd4294967296 / MOD_VAL[0], 64'd4294967296 / MOD_VAL[1],
      64'd4294967296 / MOD_VAL[2], 64'd4294967296 / MOD_VAL[3],
      64'd4294967296 / MOD_VAL[4], 64'd4294967296 / MOD_VAL[5],
      64'd4294967296 / MOD_VAL[6], 64'd4294967296 / MOD_VAL[7],
      64'd4294967296 / MOD_VAL[8], 64'd4294967296 / MOD_VAL[9]};

   // band limits in q4 feet, compared strictly
   localparam logic [19:0] LIMIT_B0 = 20'd12800;
   localparam logic [19:0] LIMIT_B1 = 20'd8000;
   localparam logic [19:0] LIMIT_B2 = 20'd4800;
   localparam logic [19:0] LIMIT_B3 = 20'd2400;
   localparam logic [19:0] LIMIT_B4 = 20'd1200;

   localparam logic [2:0] BAND_FAR   = 3'd0;
   localparam logic [2:0] BAND_1     = 3'd1;
   localparam logic [2:0] BAND_2     = 3'd2;
   localparam logic [2:0] BAND_3     = 3'd3;
   localparam logic [2:0] BAND_4     = 3'd4;
   localparam logic [2:0] BAND_SOLID = 3'd5;

   localparam logic [2:0] LEVEL_FAR   = 3'd1;
   localparam logic [2:0] LEVEL_SOLID = 3'd5;
   localparam logic [2:0] LEVEL_OFF   = 3'd0;

   localparam logic [HALF_W-1:0] HALF_FAR = 10'd600;

   typedef struct packed {
      logic              alert_enabled;
      logic              pin_active_high;
      logic [7:0]        intersection_kind_code;
      logic [7:0]        cluster_kind_code;
   } cfg_type;

   typedef struct packed {
      logic              active;
      logic [2:0]        band;
      pat_type           pat;
      logic [HALF_W-1:0] half;
   } ctl_type;

   function automatic logic [7:0] red_of(input logic [2:0] level);
      logic [7:0] red;
      case (level)
         3'd0:    red = 8'd0;
         3'd1:    red = 8'd45;
         3'd2:    red = 8'd90;
         3'd3:    red = 8'd135;
         3'd4:    red = 8'd180;
         3'd5:    red = 8'd225;
         default: red = 8'd255;
      endcase
      return red;
   endfunction

endpackage

// ===== src/dabp_classify.sv =====
module dabp_classify (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [31:0]           time_ms,
   input  logic                  alert_on,
   input  logic [19:0]           distance_q4,
   input  logic [7:0]            kind_code,
   input  dabp_pkg::cfg_type     cfg,
   output logic                  out_valid,
   output logic [31:0]           out_time,
   output dabp_pkg::modsel_type  out_sel,
   output dabp_pkg::ctl_type     out_ctl
);

   logic                 valid_ff;
   logic [31:0]          time_ff;
   dabp_pkg::modsel_type sel_ff, sel_in;
   dabp_pkg::ctl_type    ctl_ff, ctl_in;
   logic [2:0]           band;
   logic                 tri_kind;
   logic                 dbl_kind;

   always_comb begin
      if (distance_q4 > dabp_pkg::LIMIT_B0) begin
         band = dabp_pkg::BAND_FAR;
      end else if (distance_q4 > dabp_pkg::LIMIT_B1) begin
         band = dabp_pkg::BAND_1;
      end else if (distance_q4 > dabp_pkg::LIMIT_B2) begin
         band = dabp_pkg::BAND_2;
      end else if (distance_q4 > dabp_pkg::LIMIT_B3) begin
         band = dabp_pkg::BAND_3;
      end else if (distance_q4 > dabp_pkg::LIMIT_B4) begin
         band = dabp_pkg::BAND_4;
      end else begin
         band = dabp_pkg::BAND_SOLID;
      end
   end

   // intersection wins when both kind codes match
   assign tri_kind = (kind_code == cfg.intersection_kind_code);
   assign dbl_kind = !tri_kind && (kind_code == cfg.cluster_kind_code);

   always_comb begin
      ctl_in.active = cfg.alert_enabled & alert_on;
      ctl_in.band   = band;
      ctl_in.pat    = tri_kind ? dabp_pkg::PAT_TRI :
                      dbl_kind ? dabp_pkg::PAT_DBL : dabp_pkg::PAT_CAM;
      ctl_in.half   = '0;
      sel_in        = dabp_pkg::M1200;
      case (band)
         dabp_pkg::BAND_FAR: begin
            ctl_in.pat  = dabp_pkg::PAT_FAR;
            ctl_in.half = dabp_pkg::HALF_FAR;
            sel_in      = dabp_pkg::M1200;
         end
         dabp_pkg::BAND_1: begin
            ctl_in.half = tri_kind ? 10'd200 : 10'd400;
            sel_in      = tri_kind ? dabp_pkg::M1200 :
                          dbl_kind ? dabp_pkg::M1600 : dabp_pkg::M800;
         end
         dabp_pkg::BAND_2: begin
            ctl_in.half = tri_kind ? 10'd140 : 10'd280;
            sel_in      = tri_kind ? dabp_pkg::M840 :
                          dbl_kind ? dabp_pkg::M1120 : dabp_pkg::M560;
         end
         dabp_pkg::BAND_3: begin
            ctl_in.half = tri_kind ? 10'd90 : 10'd180;
            sel_in      = tri_kind ? dabp_pkg::M540 :
                          dbl_kind ? dabp_pkg::M720 : dabp_pkg::M360;
         end
         dabp_pkg::BAND_4: begin
            ctl_in.half = 10'd90;
            sel_in      = tri_kind ? dabp_pkg::M540 :
                          dbl_kind ? dabp_pkg::M360 : dabp_pkg::M180;
         end
         default: begin
            ctl_in.half = '0;
            sel_in      = dabp_pkg::M1200;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      time_ff <= time_ms;
      sel_ff  <= sel_in;
      ctl_ff  <= ctl_in;
   end

   assign out_valid = valid_ff;
   assign out_time  = time_ff;
   assign out_sel   = sel_ff;
   assign out_ctl   = ctl_ff;

endmodule

// ===== src/dabp_mod.sv =====
module dabp_mod (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [31:0]                       in_time,
   input  dabp_pkg::modsel_type              in_sel,
   input  dabp_pkg::ctl_type                 in_ctl,
   output logic                              out_valid,
   output logic [dabp_pkg::REM_W-1:0]        out_rem,
   output dabp_pkg::ctl_type                 out_ctl
);

   localparam int STAGES = 5;
   localparam int BIG_W  = dabp_pkg::SUM_W + dabp_pkg::RECIP_W;
   localparam int QM_W   = dabp_pkg::QUO_W + dabp_pkg::MOD_W;

   logic [STAGES-1:0]    valid_ff;
   dabp_pkg::ctl_type    ctl_ff [STAGES];

   // stage a: byte products
   dabp_pkg::modsel_type              sel_a_ff;
   logic [7:0]                        b0_ff;
   logic [dabp_pkg::PROD_W-1:0]       p1_ff, p1_in;
   logic [dabp_pkg::PROD_W-1:0]       p2_ff, p2_in;
   logic [dabp_pkg::PROD_W-1:0]       p3_ff, p3_in;
   logic [dabp_pkg::MOD_W-1:0]        w1, w2, w3;

   // stage b: folded sum
   dabp_pkg::modsel_type              sel_b_ff;
   logic [dabp_pkg::SUM_W-1:0]        sum_b_ff, sum_b_in;

   // stage c: quotient estimate
   dabp_pkg::modsel_type              sel_c_ff;
   logic [dabp_pkg::SUM_W-1:0]        sum_c_ff;
   logic [dabp_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic [dabp_pkg::RECIP_W-1:0]      recip;
   logic [BIG_W-1:0]                  big;

   // stage d: remainder below twice the modulus
   dabp_pkg::modsel_type              sel_d_ff;
   logic [dabp_pkg::REM_W:0]          r0_ff, r0_in;
   logic [dabp_pkg::MOD_W-1:0]        mod_c;
   logic [QM_W-1:0]                   diff;

   // stage e: final remainder
   logic [dabp_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [dabp_pkg::MOD_W-1:0]        mod_d;

   assign w1 = dabp_pkg::MOD_W'(dabp_pkg::W1_VAL[in_sel]);
   assign w2 = dabp_pkg::MOD_W'(dabp_pkg::W2_VAL[in_sel]);
   assign w3 = dabp_pkg::MOD_W'(dabp_pkg::W3_VAL[in_sel]);

   assign p1_in = dabp_pkg::PROD_W'(in_time[15:8])  * dabp_pkg::PROD_W'(w1);
   assign p2_in = dabp_pkg::PROD_W'(in_time[23:16]) * dabp_pkg::PROD_W'(w2);
   assign p3_in = dabp_pkg::PROD_W'(in_time[31:24]) * dabp_pkg::PROD_W'(w3);

   assign sum_b_in = dabp_pkg::SUM_W'(b0_ff) + dabp_pkg::SUM_W'(p1_ff)
                   + dabp_pkg::SUM_W'(p2_ff) + dabp_pkg::SUM_W'(p3_ff);

   // estimate is exact or one low
   assign recip  = dabp_pkg::RECIP_W'(dabp_pkg::RECIP_VAL[sel_b_ff]);
   assign big    = BIG_W'(sum_b_ff) * BIG_W'(recip);
   assign quo_in = big[dabp_pkg::FRAC_SH +: dabp_pkg::QUO_W];

   assign mod_c = dabp_pkg::MOD_W'(dabp_pkg::MOD_VAL[sel_c_ff]);
   assign diff  = QM_W'(sum_c_ff) - (QM_W'(quo_ff) * QM_W'(mod_c));
   assign r0_in = diff[dabp_pkg::REM_W:0];

   assign mod_d  = dabp_pkg::MOD_W'(dabp_pkg::MOD_VAL[sel_d_ff]);
   assign rem_in = (r0_ff >= {1'b0, mod_d}) ?
                   dabp_pkg::REM_W'(r0_ff - {1'b0, mod_d}) :
                   dabp_pkg::REM_W'(r0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
      ctl_ff[0] <= in_ctl;
      for (int i = 1; i < STAGES; i++) begin
         ctl_ff[i] <= ctl_ff[i-1];
      end
      sel_a_ff <= in_sel;
      b0_ff    <= in_time[7:0];
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
      sel_b_ff <= sel_a_ff;
      sum_b_ff <= sum_b_in;
      sel_c_ff <= sel_b_ff;
      sum_c_ff <= sum_b_ff;
      quo_ff   <= quo_in;
      sel_d_ff <= sel_c_ff;
      r0_ff    <= r0_in;
      rem_ff   <= rem_in;
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_rem   = rem_ff;
   assign out_ctl   = ctl_ff[STAGES-1];

   a_r0_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (r0_ff < {mod_d, 1'b0}))
      else $error("partial remainder not below twice the modulus");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |=> (rem_ff < dabp_pkg::REM_W'($past(mod_d))))
      else $error("remainder not below the modulus");

endmodule

// ===== src/dabp_pattern.sv =====
module dabp_pattern (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [dabp_pkg::REM_W-1:0]  in_rem,
   input  dabp_pkg::ctl_type           in_ctl,
   input  logic                        pin_active_high,
   output logic                        out_valid,
   output logic [2:0]                  out_drive_level,
   output logic [7:0]                  out_red_intensity,
   output logic                        out_pin_level
);

   logic                       valid_ff;
   logic [2:0]                 level_ff, level_in;
   logic [7:0]                 red_ff;
   logic                       pin_ff, pin_in;
   logic [dabp_pkg::CMP_W-1:0] r, h1, h2, h3, h4, h5;
   logic                       lit;

   assign r  = dabp_pkg::CMP_W'(in_rem);
   assign h1 = dabp_pkg::CMP_W'(in_ctl.half);
   assign h2 = {h1[dabp_pkg::CMP_W-2:0], 1'b0};
   assign h3 = h2 + h1;
   assign h4 = {h1[dabp_pkg::CMP_W-3:0], 2'b00};
   assign h5 = h4 + h1;

   always_comb begin
      case (in_ctl.pat)
         dabp_pkg::PAT_FAR: lit = (r >= h1);
         dabp_pkg::PAT_CAM: lit = (r < h1);
         dabp_pkg::PAT_DBL: lit = (r < h1) || (r > h2 && r < h3);
         dabp_pkg::PAT_TRI: lit = (r < h1) || (r > h2 && r < h3) ||
                                  (r > h4 && r < h5);
         default:           lit = 1'b0;
      endcase
   end

   always_comb begin
      if (!in_ctl.active) begin
         level_in = dabp_pkg::LEVEL_OFF;
      end else if (in_ctl.band == dabp_pkg::BAND_SOLID) begin
         level_in = dabp_pkg::LEVEL_SOLID;
      end else if (!lit) begin
         level_in = dabp_pkg::LEVEL_OFF;
      end else if (in_ctl.band == dabp_pkg::BAND_FAR) begin
         level_in = dabp_pkg::LEVEL_FAR;
      end else begin
         level_in = in_ctl.band;
      end
   end

   assign pin_in = pin_active_high ? (level_in != dabp_pkg::LEVEL_OFF) :
                                     (level_in == dabp_pkg::LEVEL_OFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      level_ff <= level_in;
      red_ff   <= dabp_pkg::red_of(level_in);
      pin_ff   <= pin_in;
   end

   assign out_valid         = valid_ff;
   assign out_drive_level   = level_ff;
   assign out_red_intensity = red_ff;
   assign out_pin_level     = pin_ff;

endmodule

// ===== src/distance_alert_blink_pattern_core.sv =====
// a word accepted on start shows on the rsp_ ports for one cycle once it has passed the pipeline
// throughput: one word per clock; busy stays low and start is taken every cycle
// the pipeline is band sort, a 5 stage modulo unit for the blink phase, and the output stage
// results cannot be held off; rsp_valid marks each one for exactly one cycle
// synchronous active high reset empties the pipeline and loads the register defaults
module distance_alert_blink_pattern_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_time_ms,
   input  logic        req_alert_on,
   input  logic [19:0] req_distance_q4,
   input  logic [7:0]  req_kind_code,
   output logic        rsp_valid,
   output logic [2:0]  rsp_drive_level,
   output logic [7:0]  rsp_red_intensity,
   output logic        rsp_pin_level,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   dabp_pkg::cfg_type    cfg_ff;
   logic                 c_valid;
   logic [31:0]          c_time;
   dabp_pkg::modsel_type c_sel;
   dabp_pkg::ctl_type    c_ctl;
   logic                 m_valid;
   logic [dabp_pkg::REM_W-1:0] m_rem;
   dabp_pkg::ctl_type    m_ctl;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alert_enabled          <= 1'b1;
         cfg_ff.pin_active_high        <= 1'b1;
         cfg_ff.intersection_kind_code <= 8'd0;
         cfg_ff.cluster_kind_code      <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dabp_pkg::CSR_ALERT_ENABLED:   cfg_ff.alert_enabled          <= csr_wdata[0];
            dabp_pkg::CSR_PIN_ACTIVE_HIGH: cfg_ff.pin_active_high        <= csr_wdata[0];
            dabp_pkg::CSR_INTERSECT_KIND:  cfg_ff.intersection_kind_code <= csr_wdata;
            dabp_pkg::CSR_CLUSTER_KIND:    cfg_ff.cluster_kind_code      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dabp_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .time_ms     (req_time_ms),
      .alert_on    (req_alert_on),
      .distance_q4 (req_distance_q4),
      .kind_code   (req_kind_code),
      .cfg         (cfg_ff),
      .out_valid   (c_valid),
      .out_time    (c_time),
      .out_sel     (c_sel),
      .out_ctl     (c_ctl)
   );

   dabp_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_time   (c_time),
      .in_sel    (c_sel),
      .in_ctl    (c_ctl),
      .out_valid (m_valid),
      .out_rem   (m_rem),
      .out_ctl   (m_ctl)
   );

   dabp_pattern u_pattern (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (m_valid),
      .in_rem            (m_rem),
      .in_ctl            (m_ctl),
      .pin_active_high   (cfg_ff.pin_active_high),
      .out_valid         (rsp_valid),
      .out_drive_level   (rsp_drive_level),
      .out_red_intensity (rsp_red_intensity),
      .out_pin_level     (rsp_pin_level)
   );

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_level <= dabp_pkg::LEVEL_SOLID))
      else $error("drive level out of range");

   a_red_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive_level == dabp_pkg::LEVEL_OFF) == (rsp_red_intensity == 8'd0)))
      else $error("red intensity disagrees with drive level");

endmodule
